@@ sv/ucv_pkg.sv @@
// ============================================================================
// ucv_pkg - shared constants for the seconds-to-civil-time pipeline
// Bias offsets that keep every division non-negative, reciprocal constants
// for the small fixed divisions, and the month start table of a March year.
// ============================================================================
package ucv_pkg;

  // Whole days added to the input so that the biased count never goes negative.
  localparam longint unsigned DAY_BIAS = ((64'd1 << 55) + 64'd86399) / 64'd86400;
  // The same bias in seconds; its low seven bits are zero.
  localparam logic [56:0] SEC_BIAS = 57'(DAY_BIAS * 64'd86400);

  // Whole eras added before the era split, and the leftover day offset that
  // also carries the shift of the epoch to 0000-03-01.
  localparam longint unsigned ERA_BIAS =
    (DAY_BIAS - 64'd719468 + 64'd146096) / 64'd146097;
  localparam logic [47:0] W_BIAS = 48'(ERA_BIAS * 64'd146097 + 64'd719468 - DAY_BIAS);
  // Years to take back out of the era count, modulo 2^32.
  localparam logic [31:0] YEAR_BIAS = 32'(ERA_BIAS * 64'd400);

  // Long division by 86400 runs as a shift by 7 and a division by 675.
  localparam int D1_WIDTH   = 64;
  localparam int D1_CHUNK   = 16;
  localparam int D1_DIVISOR = 675;
  localparam int D1_DBITS   = 10;
  localparam int D2_WIDTH   = 48;
  localparam int D2_CHUNK   = 12;
  localparam int D2_DIVISOR = 146097;
  localparam int D2_DBITS   = 18;

  // Last day of an era (the extra leap day of the fourth century).
  localparam logic [17:0] DOE_LAST = 18'd146096;

  // Reciprocals: floor(n/d) == (n * ceil(2^(w+l)/d)) >> (w+l) for n < 2^w.
  localparam logic [16:0] RCP_365_W16 = 17'(((64'd1 << 25) + 64'd364) / 64'd365);
  localparam logic [16:0] RCP_9131    = 17'(((64'd1 << 30) + 64'd9130) / 64'd9131);
  localparam logic [15:0] RCP_15      = 16'(((64'd1 << 19) + 64'd14) / 64'd15);
  localparam logic [18:0] RCP_7       = 19'(((64'd1 << 21) + 64'd6) / 64'd7);
  localparam logic [11:0] RCP_60      = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
  localparam logic [18:0] RCP_365_W18 = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  RCP_100     = 10'(((64'd1 << 16) + 64'd99) / 64'd100);

  // Month index of a March-based year at which January starts.
  localparam logic [3:0] MP_JAN = 4'd10;
  localparam int MONTHS = 12;

  // First day of each month in a year that starts on March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] start;
    unique case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

@@ sv/unix_seconds_to_civil_time_unit.sv @@
// ============================================================================
// unix_seconds_to_civil_time_unit - Unix seconds to proleptic Gregorian date
// Splits a signed second count into days and time of day, the days into
// 400-year eras, and the era day into year, month, day and weekday.
// ============================================================================
//
//   Channel  Handshake             Payload
//   -------  --------------------  ------------------------------------------
//   request  in_valid / in_ready   seconds (56-bit signed)
//   result   out_valid / out_ready year, month, day, hour, minute, second,
//                                  weekday
//
// One request enters per cycle while in_ready is high. The pipeline is
// the two chunked constant dividers (8 stages each: one multiply and one
// subtract stage per chunk) plus nine stages of calendar and clock
// arithmetic.
// Reset clears only the stage valid bits; there is no stored state.
// A stalled result holds in the output register while earlier stages keep
// filling their empty slots; in_ready drops only when every stage is full.
//
module unix_seconds_to_civil_time_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [55:0] seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second,
  output logic [2:0]         weekday
);

  // --------------------------------------------------------------------------
  // Stage A: bias the count so every later division sees a non-negative value.
  // The bias is a multiple of 86400 with seven zero low bits, so the low seven
  // bits of the request pass straight into the time of day.
  // --------------------------------------------------------------------------
  logic        a_v, a_en;
  logic [49:0] a_num;
  logic [6:0]  a_lo7;
  logic [56:0] sec_biased;

  logic        d1_in_ready, d1_v;
  logic [63:0] d1_quo;
  logic [9:0]  d1_rem;
  logic [6:0]  d1_side;

  assign sec_biased = {seconds[55], seconds} + ucv_pkg::SEC_BIAS;
  assign a_en       = !a_v || d1_in_ready;
  assign in_ready   = a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_en) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_num <= sec_biased[56:7];
      a_lo7 <= seconds[6:0];
    end
  end

  // Days (plus bias) = floor(count / 128 / 675); time of day from remainder.
  logic b_en;

  ucv_cdiv #(
    .DW      (ucv_pkg::D1_WIDTH),
    .CHUNK   (ucv_pkg::D1_CHUNK),
    .DIVISOR (ucv_pkg::D1_DIVISOR),
    .DL      (ucv_pkg::D1_DBITS),
    .SW      (7)
  ) u_day_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_v),
    .in_ready  (d1_in_ready),
    .dividend  ({14'd0, a_num}),
    .in_side   (a_lo7),
    .out_valid (d1_v),
    .out_ready (b_en),
    .quotient  (d1_quo),
    .remainder (d1_rem),
    .out_side  (d1_side)
  );

  // --------------------------------------------------------------------------
  // Stage B: shift the epoch to 0000-03-01 and add whole eras of bias.
  // --------------------------------------------------------------------------
  logic        b_v;
  logic [47:0] b_w;
  logic [16:0] b_tod;

  logic        d2_in_ready, d2_v;
  logic [47:0] d2_quo;
  logic [17:0] d2_rem;
  logic [16:0] d2_side;

  assign b_en = !b_v || d2_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_en) begin
      b_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_w   <= d1_quo[47:0] + ucv_pkg::W_BIAS;
      b_tod <= {d1_rem, d1_side};
    end
  end

  // Era (plus bias) and day of era.
  logic c_en;

  ucv_cdiv #(
    .DW      (ucv_pkg::D2_WIDTH),
    .CHUNK   (ucv_pkg::D2_CHUNK),
    .DIVISOR (ucv_pkg::D2_DIVISOR),
    .DL      (ucv_pkg::D2_DBITS),
    .SW      (17)
  ) u_era_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_v),
    .in_ready  (d2_in_ready),
    .dividend  (b_w),
    .in_side   (b_tod),
    .out_valid (d2_v),
    .out_ready (c_en),
    .quotient  (d2_quo),
    .remainder (d2_rem),
    .out_side  (d2_side)
  );

  // --------------------------------------------------------------------------
  // Stage C: reciprocal products for doe/1460, doe/36524, tod/60, the weekday
  // quotient, and the era scaled to years.
  // --------------------------------------------------------------------------
  logic        c_v, d_en;
  logic [6:0]  c_a;
  logic [2:0]  c_b;
  logic        c_c;
  logic [17:0] c_doe;
  logic [10:0] c_mt;
  logic [16:0] c_tod;
  logic [31:0] c_ey;
  logic [14:0] c_wq;

  logic [32:0] prod_a;
  logic [32:0] prod_b;
  logic [30:0] prod_t;
  logic [18:0] wk_num;
  logic [37:0] prod_w;

  assign prod_a = d2_rem[17:2] * ucv_pkg::RCP_365_W16;
  assign prod_b = d2_rem[17:2] * ucv_pkg::RCP_9131;
  assign prod_t = d2_side[16:2] * ucv_pkg::RCP_15;
  assign wk_num = 19'(d2_rem) + 19'd6;
  assign prod_w = wk_num * ucv_pkg::RCP_7;

  assign c_en = !c_v || d_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (c_en) begin
      c_v <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_a   <= prod_a[25 +: 7];
      c_b   <= prod_b[30 +: 3];
      c_c   <= (d2_rem == ucv_pkg::DOE_LAST);
      c_doe <= d2_rem;
      c_mt  <= prod_t[19 +: 11];
      c_tod <= d2_side;
      c_ey  <= d2_quo[31:0] * 32'd400;
      c_wq  <= prod_w[21 +: 15];
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: leap-corrected day count, seconds, weekday, hour product.
  // --------------------------------------------------------------------------
  logic        d_v, e_en;
  logic [17:0] d_ny;
  logic [17:0] d_doe;
  logic [10:0] d_mt;
  logic [5:0]  d_sec;
  logic [4:0]  d_hq;
  logic [2:0]  d_wd;
  logic [31:0] d_year;
  logic [22:0] prod_h;

  assign prod_h = c_mt * ucv_pkg::RCP_60;
  assign d_en   = !d_v || e_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (d_en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (d_en) begin
      d_ny   <= c_doe - 18'(c_a) + 18'(c_b) - 18'(c_c);
      d_doe  <= c_doe;
      d_mt   <= c_mt;
      d_sec  <= 6'(c_tod - (17'(c_mt) * 17'd60));
      d_hq   <= prod_h[17 +: 5];
      d_wd   <= 3'((19'(c_doe) + 19'd6) - (19'(c_wq) * 19'd7));
      d_year <= c_ey - ucv_pkg::YEAR_BIAS;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: year of era product; minute from hour.
  // --------------------------------------------------------------------------
  logic        e_v, f_en;
  logic [8:0]  e_yoe;
  logic [17:0] e_doe;
  logic [4:0]  e_hour;
  logic [5:0]  e_min;
  logic [5:0]  e_sec;
  logic [2:0]  e_wd;
  logic [31:0] e_year;
  logic [36:0] prod_y;

  assign prod_y = d_ny * ucv_pkg::RCP_365_W18;
  assign e_en   = !e_v || f_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (e_en) begin
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (e_en) begin
      e_yoe  <= prod_y[27 +: 9];
      e_doe  <= d_doe;
      e_hour <= d_hq;
      e_min  <= 6'(d_mt - (11'(d_hq) * 11'd60));
      e_sec  <= d_sec;
      e_wd   <= d_wd;
      e_year <= d_year;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: centuries in the year of era; fold the year of era into the year.
  // --------------------------------------------------------------------------
  logic        f_v, g_en;
  logic [8:0]  f_yoe;
  logic [1:0]  f_c100;
  logic [17:0] f_doe;
  logic [4:0]  f_hour;
  logic [5:0]  f_min;
  logic [5:0]  f_sec;
  logic [2:0]  f_wd;
  logic [31:0] f_year;
  logic [18:0] prod_c;

  assign prod_c = e_yoe * ucv_pkg::RCP_100;
  assign f_en   = !f_v || g_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (f_en) begin
      f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      f_yoe  <= e_yoe;
      f_c100 <= prod_c[16 +: 2];
      f_doe  <= e_doe;
      f_hour <= e_hour;
      f_min  <= e_min;
      f_sec  <= e_sec;
      f_wd   <= e_wd;
      f_year <= e_year + 32'(e_yoe);
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: day of the March-based year.
  // --------------------------------------------------------------------------
  logic        g_v, h_en;
  logic [8:0]  g_doy;
  logic [4:0]  g_hour;
  logic [5:0]  g_min;
  logic [5:0]  g_sec;
  logic [2:0]  g_wd;
  logic [31:0] g_year;

  assign g_en = !g_v || h_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (g_en) begin
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (g_en) begin
      g_doy  <= 9'(f_doe - ((18'(f_yoe) * 18'd365) + 18'(f_yoe[8:2]) - 18'(f_c100)));
      g_hour <= f_hour;
      g_min  <= f_min;
      g_sec  <= f_sec;
      g_wd   <= f_wd;
      g_year <= f_year;
    end
  end

  // --------------------------------------------------------------------------
  // Stage H: month index, counting the month starts already passed.
  // --------------------------------------------------------------------------
  logic        h_v, o_en;
  logic [3:0]  h_mp;
  logic [8:0]  h_doy;
  logic [4:0]  h_hour;
  logic [5:0]  h_min;
  logic [5:0]  h_sec;
  logic [2:0]  h_wd;
  logic [31:0] h_year;
  logic [ucv_pkg::MONTHS-2:0] past_start;

  always_comb begin
    for (int i = 0; i < ucv_pkg::MONTHS - 1; i++) begin
      past_start[i] = (g_doy >= ucv_pkg::month_start(4'(i + 1)));
    end
  end

  assign h_en = !h_v || o_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (h_en) begin
      h_v <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (h_en) begin
      h_mp   <= 4'($countones(past_start));
      h_doy  <= g_doy;
      h_hour <= g_hour;
      h_min  <= g_min;
      h_sec  <= g_sec;
      h_wd   <= g_wd;
      h_year <= g_year;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: calendar month and day; January and February belong to
  // the next civil year.
  // --------------------------------------------------------------------------
  logic        o_v;
  logic [31:0] o_year;
  logic [3:0]  o_month;
  logic [4:0]  o_day;
  logic [4:0]  o_hour;
  logic [5:0]  o_minute;
  logic [5:0]  o_second;
  logic [2:0]  o_weekday;

  assign o_en = !o_v || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (o_en) begin
      o_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      o_year    <= h_year + 32'(h_mp >= ucv_pkg::MP_JAN);
      o_month   <= (h_mp >= ucv_pkg::MP_JAN) ? (h_mp - 4'd9) : (h_mp + 4'd3);
      o_day     <= 5'(h_doy - ucv_pkg::month_start(h_mp) + 9'd1);
      o_hour    <= h_hour;
      o_minute  <= h_min;
      o_second  <= h_sec;
      o_weekday <= h_wd;
    end
  end

  assign out_valid = o_v;
  assign year      = o_year;
  assign month     = o_month;
  assign day       = o_day;
  assign hour      = o_hour;
  assign minute    = o_minute;
  assign second    = o_second;
  assign weekday   = o_weekday;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // Era divider remainder stays inside one era.
  a_doe_range: assert property (@(posedge clk) disable iff (rst)
    c_v |-> (c_doe <= ucv_pkg::DOE_LAST))
    else $error("day of era out of range");

  // Year of era from the reciprocal product stays below 400.
  a_yoe_range: assert property (@(posedge clk) disable iff (rst)
    e_v |-> (e_yoe < 9'd400))
    else $error("year of era out of range");

  // Delivered date fields are calendar values.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    o_v |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_day != 5'd0))
    else $error("month or day out of range");

  // Delivered clock fields are in range.
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    o_v |-> (o_hour < 5'd24 && o_minute < 6'd60 && o_second < 6'd60 &&
             o_weekday < 3'd7))
    else $error("time of day or weekday out of range");

endmodule

@@ sv/ucv_cdiv.sv @@
// ============================================================================
// ucv_cdiv - pipelined long division by a constant
// Splits the dividend into chunks, most significant first; each chunk takes
// one multiply stage (reciprocal quotient digit) and one subtract stage
// (new remainder). Elastic valid/ready stages with a sideband that rides along.
// ============================================================================
module ucv_cdiv #(
  parameter int DW      = 64,
  parameter int CHUNK   = 16,
  parameter int DIVISOR = 675,
  parameter int DL      = 10,
  parameter int SW      = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] quotient,
  output logic [DL-1:0] remainder,
  output logic [SW-1:0] out_side
);

  localparam int CHUNKS = DW / CHUNK;
  localparam int N      = CHUNK + DL;
  localparam longint unsigned RECIP_L =
    ((64'd1 << (N + DL)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [N:0]    RECIP = (N + 1)'(RECIP_L);
  localparam logic [DL-1:0] DIV_V = DL'(DIVISOR);

  // Multiply stages
  logic              p_v  [CHUNKS];
  logic [DW-1:0]     p_dd [CHUNKS];
  logic [DW-1:0]     p_qt [CHUNKS];
  logic [N-1:0]      p_nn [CHUNKS];
  logic [CHUNK-1:0]  p_qd [CHUNKS];
  logic [SW-1:0]     p_sb [CHUNKS];
  // Subtract stages
  logic              r_v  [CHUNKS];
  logic [DW-1:0]     r_dd [CHUNKS];
  logic [DW-1:0]     r_qt [CHUNKS];
  logic [DL-1:0]     r_rm [CHUNKS];
  logic [SW-1:0]     r_sb [CHUNKS];

  logic [CHUNKS-1:0] p_en;
  logic [CHUNKS-1:0] r_en;

  for (genvar j = 0; j < CHUNKS; j++) begin : g_chunk
    logic          src_v;
    logic [DW-1:0] src_dd;
    logic [DW-1:0] src_qt;
    logic [DL-1:0] src_rm;
    logic [SW-1:0] src_sb;
    logic          down_en;
    logic [N-1:0]  n_cur;
    logic [2*N:0]  prod;
    logic [N-1:0]  sub;
    logic [DW-1:0] qt_upd;

    if (j == 0) begin : g_first
      assign src_v  = in_valid;
      assign src_dd = dividend;
      assign src_qt = '0;
      assign src_rm = '0;
      assign src_sb = in_side;
    end else begin : g_next
      assign src_v  = r_v[j-1];
      assign src_dd = r_dd[j-1];
      assign src_qt = r_qt[j-1];
      assign src_rm = r_rm[j-1];
      assign src_sb = r_sb[j-1];
    end

    if (j == CHUNKS - 1) begin : g_last
      assign down_en = out_ready;
    end else begin : g_mid
      assign down_en = p_en[j+1];
    end

    assign p_en[j] = !p_v[j] || r_en[j];
    assign r_en[j] = !r_v[j] || down_en;

    // Partial dividend: remainder so far followed by the next chunk
    assign n_cur = {src_rm, src_dd[DW-1-j*CHUNK -: CHUNK]};
    assign prod  = n_cur * RECIP;

    always_ff @(posedge clk) begin
      if (rst) begin
        p_v[j] <= 1'b0;
      end else if (p_en[j]) begin
        p_v[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (p_en[j]) begin
        p_dd[j] <= src_dd;
        p_qt[j] <= src_qt;
        p_nn[j] <= n_cur;
        p_qd[j] <= prod[N+DL +: CHUNK];
        p_sb[j] <= src_sb;
      end
    end

    assign sub = p_nn[j] - (N'(p_qd[j]) * N'(DIV_V));

    always_comb begin
      qt_upd = p_qt[j];
      qt_upd[DW-1-j*CHUNK -: CHUNK] = p_qd[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        r_v[j] <= 1'b0;
      end else if (r_en[j]) begin
        r_v[j] <= p_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (r_en[j]) begin
        r_dd[j] <= p_dd[j];
        r_qt[j] <= qt_upd;
        r_rm[j] <= sub[DL-1:0];
        r_sb[j] <= p_sb[j];
      end
    end
  end

  assign in_ready  = p_en[0];
  assign out_valid = r_v[CHUNKS-1];
  assign quotient  = r_qt[CHUNKS-1];
  assign remainder = r_rm[CHUNKS-1];
  assign out_side  = r_sb[CHUNKS-1];

endmodule
